@@ design/sts_pkg.sv @@
// shared types and constants for the safety tier supervisor
package sts_pkg;

	localparam int BOOT_SLOTS = 5;
	localparam int PTR_W = (BOOT_SLOTS > 1) ? $clog2(BOOT_SLOTS) : 1;
	localparam int CNT_W = $clog2(BOOT_SLOTS + 1);
	localparam int THR_W = 3;
	localparam int TIME_W = 32;
	localparam int EV_W = 4;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(10 * 60 * 1000);
	localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(5);

	typedef enum logic [1:0] {
		TIER_NORMAL = 2'd0,
		TIER_DEGRADED = 2'd1,
		TIER_SAFE = 2'd2,
		TIER_FAULT = 2'd3
	} tier_t;

	typedef enum logic [EV_W-1:0] {
		EV_HB_MISS = 4'd0,
		EV_HB_RECOVER = 4'd1,
		EV_ESTOP = 4'd2,
		EV_OVERCURRENT = 4'd3,
		EV_WATCHDOG = 4'd4,
		EV_SENSOR_FAIL = 4'd5,
		EV_TRUST_VIOLATION = 4'd6,
		EV_BOOT_DONE = 4'd7,
		EV_RESUME = 4'd8
	} event_t;

	typedef enum logic {
		REG_BOOT_WINDOW = 1'b0,
		REG_BOOT_THRESHOLD = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [EV_W-1:0] event_req;
		logic [TIME_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [1:0] tier;
		logic changed;
	} rsp_t;

	typedef struct packed {
		logic record;
		logic [TIME_W-1:0] now_ms;
	} ring_ctl_t;

endpackage

@@ design/safety_tier_state_machine.sv @@
// top level: request register, tier logic, response register and config registers
// Four-tier safety supervisor (normal, degraded, safe, fault). Each request carries an event
// code and a millisecond timestamp and yields exactly one response with the new tier and a
// changed flag. A request can be taken every cycle unless stalled; request and response are
// held in the request and response registers, and the five-slot boot age compare feeding the
// tier decode is the combinational path between them. A stalled response holds the request
// register, which then stalls the input. Fault is left only by reset. The user must write boot
// window and threshold through the APB port only while no request is in flight (not enforced).
module safety_tier_state_machine (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input sts_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output sts_pkg::rsp_t rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [sts_pkg::APB_AW-1:0] paddr,
	input logic [sts_pkg::APB_DW-1:0] pwdata,
	output logic [sts_pkg::APB_DW-1:0] prdata,
	output logic pready
);

	logic req_valid_s1;
	sts_pkg::req_t req_s1;
	logic rsp_valid_q;
	sts_pkg::rsp_t rsp_q;
	logic [sts_pkg::TIME_W-1:0] window_q;
	logic [sts_pkg::THR_W-1:0] threshold_q;
	logic advance;
	logic trip;
	sts_pkg::ring_ctl_t ring_ctl;
	sts_pkg::rsp_t rsp_d;
	sts_pkg::reg_idx_t reg_idx;

	assign advance = req_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = req_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	sts_tier_fsm u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.event_req(req_s1.event_req),
		.now_ms(req_s1.now_ms),
		.trip(trip),
		.ring_ctl(ring_ctl),
		.rsp(rsp_d)
	);

	sts_boot_ring u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ring_ctl),
		.window(window_q),
		.threshold(threshold_q),
		.trip(trip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// config registers
	assign reg_idx = sts_pkg::reg_idx_t'(paddr[2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= sts_pkg::WINDOW_RESET;
			threshold_q <= sts_pkg::THRESH_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				sts_pkg::REG_BOOT_WINDOW: window_q <= pwdata;
				sts_pkg::REG_BOOT_THRESHOLD: threshold_q <= pwdata[sts_pkg::THR_W-1:0];
				default: window_q <= window_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sts_pkg::REG_BOOT_WINDOW: prdata = window_q;
			sts_pkg::REG_BOOT_THRESHOLD: prdata = sts_pkg::APB_DW'(threshold_q);
			default: prdata = '0;
		endcase
	end

endmodule

@@ design/sts_boot_ring.sv @@
// ring of boot stamps and the recent boot check
module sts_boot_ring (
	input logic clk,
	input logic arst_n,
	input sts_pkg::ring_ctl_t ctl,
	input logic [sts_pkg::TIME_W-1:0] window,
	input logic [sts_pkg::THR_W-1:0] threshold,
	output logic trip
);

	localparam int CMP_W = (sts_pkg::CNT_W > sts_pkg::THR_W) ? sts_pkg::CNT_W : sts_pkg::THR_W;

	logic [sts_pkg::TIME_W-1:0] stamps_q [sts_pkg::BOOT_SLOTS];
	logic [sts_pkg::PTR_W-1:0] ptr_q;
	logic [sts_pkg::CNT_W-1:0] filled_q;
	logic [sts_pkg::CNT_W-1:0] recent;
	logic [sts_pkg::TIME_W-1:0] age;

	always_ff @(posedge clk) begin
		if (ctl.record) begin
			stamps_q[ptr_q] <= ctl.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			filled_q <= '0;
		end else if (ctl.record) begin
			if (ptr_q == sts_pkg::PTR_W'(sts_pkg::BOOT_SLOTS - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (filled_q != sts_pkg::CNT_W'(sts_pkg::BOOT_SLOTS)) begin
				filled_q <= filled_q + 1'b1;
			end
		end
	end

	// count written stamps younger than the window
	always_comb begin
		recent = '0;
		age = '0;
		for (int i = 0; i < sts_pkg::BOOT_SLOTS; i++) begin
			age = ctl.now_ms - stamps_q[i];
			if ((sts_pkg::CNT_W'(i) < filled_q) && (age < window)) begin
				recent = recent + 1'b1;
			end
		end
	end

	assign trip = CMP_W'(recent) >= CMP_W'(threshold);

endmodule

@@ design/sts_tier_fsm.sv @@
// tier state register and transition logic
module sts_tier_fsm (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [sts_pkg::EV_W-1:0] event_req,
	input logic [sts_pkg::TIME_W-1:0] now_ms,
	input logic trip,
	output sts_pkg::ring_ctl_t ring_ctl,
	output sts_pkg::rsp_t rsp
);

	sts_pkg::tier_t tier_q;
	sts_pkg::tier_t tier_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tier_q <= sts_pkg::TIER_NORMAL;
		end else if (fire) begin
			tier_q <= tier_d;
		end
	end

	always_comb begin
		tier_d = tier_q;
		ring_ctl.record = 1'b0;
		ring_ctl.now_ms = now_ms;
		case (tier_q)
			sts_pkg::TIER_NORMAL: begin
				if (event_req inside {[sts_pkg::EV_ESTOP:sts_pkg::EV_TRUST_VIOLATION]}) begin
					tier_d = sts_pkg::TIER_DEGRADED;
				end
			end
			sts_pkg::TIER_DEGRADED: begin
				if (event_req inside {sts_pkg::EV_HB_MISS,
						[sts_pkg::EV_ESTOP:sts_pkg::EV_TRUST_VIOLATION]}) begin
					tier_d = sts_pkg::TIER_SAFE;
				end else if (event_req inside {sts_pkg::EV_HB_RECOVER, sts_pkg::EV_RESUME}) begin
					tier_d = sts_pkg::TIER_NORMAL;
				end
			end
			sts_pkg::TIER_SAFE: begin
				if (event_req == sts_pkg::EV_RESUME) begin
					tier_d = sts_pkg::TIER_NORMAL;
				end else if (event_req == sts_pkg::EV_BOOT_DONE) begin
					ring_ctl.record = fire;
				end else if (event_req inside {sts_pkg::EV_ESTOP, sts_pkg::EV_WATCHDOG,
						sts_pkg::EV_SENSOR_FAIL, sts_pkg::EV_TRUST_VIOLATION}) begin
					if (trip) begin
						tier_d = sts_pkg::TIER_FAULT;
					end
				end
			end
			default: begin
				tier_d = tier_q;
			end
		endcase
		rsp.tier = tier_d;
		rsp.changed = (tier_d != tier_q);
	end

endmodule

@@ design/sts_checker.sv @@
// port-level checks for the safety tier supervisor and their bind
module sts_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input sts_pkg::rsp_t rsp
);

	logic rsp_take;
	logic [1:0] last_tier_q;

	assign rsp_take = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tier_q <= sts_pkg::TIER_NORMAL;
		end else if (rsp_take) begin
			last_tier_q <= rsp.tier;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> ##1 rsp_valid)
		else $error("response missing after request");

	a_unchanged_tier: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && !rsp.changed |-> rsp.tier == last_tier_q)
		else $error("tier moved without changed flag");

	a_fault_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && rsp.changed && rsp.tier == sts_pkg::TIER_FAULT
			|-> last_tier_q == sts_pkg::TIER_SAFE)
		else $error("fault entered from a tier other than safe");

	a_fault_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && last_tier_q == sts_pkg::TIER_FAULT
			|-> rsp.tier == sts_pkg::TIER_FAULT && !rsp.changed)
		else $error("fault tier left");

endmodule

bind safety_tier_state_machine sts_checker u_sts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp(rsp)
);

@@ verif/safety_tier_state_machine_tb.sv @@
// testbench for the safety tier supervisor: tier prediction, random event traffic, apb setup
`timescale 1ns / 1ps

module safety_tier_state_machine_tb;

	localparam logic [sts_pkg::EV_W-1:0] EV_UNUSED_LO = 4'd9;
	localparam logic [sts_pkg::EV_W-1:0] EV_UNUSED_HI = 4'd15;
	localparam int DRAIN_CYCLES = 4;
	localparam int REQ_PER_PHASE = 56;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	sts_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	sts_pkg::rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [sts_pkg::APB_AW-1:0] paddr;
	logic [sts_pkg::APB_DW-1:0] pwdata;
	logic [sts_pkg::APB_DW-1:0] prdata;
	logic pready;

	// tier tracking and boot ring as the block should hold them
	sts_pkg::tier_t tier_now;
	logic [sts_pkg::TIME_W-1:0] boot_ring [sts_pkg::BOOT_SLOTS];
	int ring_ptr;
	int ring_fill;
	logic [sts_pkg::TIME_W-1:0] cfg_window;
	logic [sts_pkg::THR_W-1:0] cfg_thr;

	sts_pkg::rsp_t tier_q [$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic rsp_hold = 1'b0;
	logic fault_allowed = 1'b0;
	logic [sts_pkg::TIME_W-1:0] clock_ms = '0;

	safety_tier_state_machine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sts_pkg::req_t make_req(logic [sts_pkg::EV_W-1:0] ev,
			logic [sts_pkg::TIME_W-1:0] now);
		sts_pkg::req_t r;
		r.event_req = ev;
		r.now_ms = now;
		return r;
	endfunction

	function automatic logic checks_boots(logic [sts_pkg::EV_W-1:0] ev);
		return ev == sts_pkg::EV_ESTOP || ev == sts_pkg::EV_WATCHDOG ||
			ev == sts_pkg::EV_SENSOR_FAIL || ev == sts_pkg::EV_TRUST_VIOLATION;
	endfunction

	function automatic int count_recent_boots(logic [sts_pkg::TIME_W-1:0] now);
		int n;
		logic [sts_pkg::TIME_W-1:0] age;
		n = 0;
		for (int i = 0; i < ring_fill; i++) begin
			age = now - boot_ring[i];
			if (age < cfg_window)
				n++;
		end
		return n;
	endfunction

	function automatic logic boots_force_fault(logic [sts_pkg::EV_W-1:0] ev,
			logic [sts_pkg::TIME_W-1:0] now);
		return tier_now == sts_pkg::TIER_SAFE && checks_boots(ev) &&
			count_recent_boots(now) >= cfg_thr;
	endfunction

	function automatic sts_pkg::rsp_t next_tier(sts_pkg::req_t item);
		sts_pkg::tier_t nxt;
		sts_pkg::rsp_t r;
		logic [sts_pkg::EV_W-1:0] ev;
		ev = item.event_req;
		nxt = tier_now;
		case (tier_now)
			sts_pkg::TIER_NORMAL: begin
				if (ev >= sts_pkg::EV_ESTOP && ev <= sts_pkg::EV_TRUST_VIOLATION)
					nxt = sts_pkg::TIER_DEGRADED;
			end
			sts_pkg::TIER_DEGRADED: begin
				if (ev == sts_pkg::EV_HB_MISS ||
						(ev >= sts_pkg::EV_ESTOP && ev <= sts_pkg::EV_TRUST_VIOLATION))
					nxt = sts_pkg::TIER_SAFE;
				else if (ev == sts_pkg::EV_HB_RECOVER || ev == sts_pkg::EV_RESUME)
					nxt = sts_pkg::TIER_NORMAL;
			end
			sts_pkg::TIER_SAFE: begin
				if (ev == sts_pkg::EV_RESUME) begin
					nxt = sts_pkg::TIER_NORMAL;
				end else if (ev == sts_pkg::EV_BOOT_DONE) begin
					boot_ring[ring_ptr] = item.now_ms;
					ring_ptr = (ring_ptr == sts_pkg::BOOT_SLOTS - 1) ? 0 : ring_ptr + 1;
					if (ring_fill < sts_pkg::BOOT_SLOTS)
						ring_fill++;
				end else if (boots_force_fault(ev, item.now_ms)) begin
					nxt = sts_pkg::TIER_FAULT;
				end
			end
			default: begin
			end
		endcase
		r.changed = (nxt != tier_now);
		r.tier = nxt;
		tier_now = nxt;
		return r;
	endfunction

	// mostly walks toward safe and exercises the boot ring, with stray codes mixed in
	function automatic sts_pkg::req_t next_random_event();
		logic [sts_pkg::EV_W-1:0] ev;
		int unsigned r;
		r = $urandom_range(99);
		ev = sts_pkg::EV_W'($urandom_range(EV_UNUSED_HI, sts_pkg::EV_HB_MISS));
		case (tier_now)
			sts_pkg::TIER_NORMAL: begin
				if (r < 65)
					ev = sts_pkg::EV_W'($urandom_range(sts_pkg::EV_TRUST_VIOLATION,
						sts_pkg::EV_ESTOP));
			end
			sts_pkg::TIER_DEGRADED: begin
				if (r < 35)
					ev = sts_pkg::EV_W'($urandom_range(sts_pkg::EV_TRUST_VIOLATION,
						sts_pkg::EV_HB_MISS));
				else if (r < 55)
					ev = r[0] ? sts_pkg::EV_HB_RECOVER : sts_pkg::EV_RESUME;
				else if (r < 65)
					ev = sts_pkg::EV_BOOT_DONE;
			end
			sts_pkg::TIER_SAFE: begin
				if (r < 35)
					ev = sts_pkg::EV_BOOT_DONE;
				else if (r < 70)
					ev = sts_pkg::EV_W'($urandom_range(sts_pkg::EV_TRUST_VIOLATION,
						sts_pkg::EV_ESTOP));
				else if (r < 78)
					ev = r[0] ? sts_pkg::EV_HB_MISS : sts_pkg::EV_HB_RECOVER;
				else if (r < 85)
					ev = sts_pkg::EV_RESUME;
			end
			default: begin
			end
		endcase
		r = $urandom_range(99);
		if (r < 50)
			clock_ms += $urandom_range(16);
		else if (r < 75)
			clock_ms += $urandom_range(cfg_window);
		else if (r < 88 && ring_fill > 0)
			clock_ms = boot_ring[$urandom_range(ring_fill - 1)] + cfg_window -
				$urandom_range(1);
		else if (r < 95)
			clock_ms = $urandom();
		else
			clock_ms = 32'hFFFF_FFF0 + $urandom_range(15);
		if (!fault_allowed && boots_force_fault(ev, clock_ms))
			ev = sts_pkg::EV_BOOT_DONE;
		return make_req(ev, clock_ms);
	endfunction

	task automatic note_mismatch(string what, logic [sts_pkg::APB_DW-1:0] want,
			logic [sts_pkg::APB_DW-1:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
	endtask

	always @(posedge clk) begin : check_rsp
		sts_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (tier_q.size() == 0) begin
				note_mismatch("unexpected response", '0, sts_pkg::APB_DW'(rsp));
			end else begin
				want = tier_q.pop_front();
				if (rsp.tier !== want.tier)
					note_mismatch("tier", sts_pkg::APB_DW'(want.tier),
						sts_pkg::APB_DW'(rsp.tier));
				if (rsp.changed !== want.changed)
					note_mismatch("changed", sts_pkg::APB_DW'(want.changed),
						sts_pkg::APB_DW'(rsp.changed));
			end
		end
	end

	always @(negedge clk)
		rsp_stall <= rsp_hold || ($urandom_range(99) < recv_stall_pct);

	task automatic send_event(sts_pkg::req_t item);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (req_stall);
		tier_q.push_back(next_tier(item));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (tier_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write_check(sts_pkg::reg_idx_t idx, logic [sts_pkg::APB_DW-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= sts_pkg::APB_AW'(4 * idx);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== value)
			note_mismatch(idx == sts_pkg::REG_BOOT_WINDOW ? "window readback" :
				"threshold readback", value, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_boot_limits(logic [sts_pkg::TIME_W-1:0] window,
			logic [sts_pkg::THR_W-1:0] thr);
		wait_idle();
		apb_write_check(sts_pkg::REG_BOOT_WINDOW, window);
		apb_write_check(sts_pkg::REG_BOOT_THRESHOLD, sts_pkg::APB_DW'(thr));
		cfg_window = window;
		cfg_thr = thr;
	endtask

	task automatic set_idling(int sender_pct, int receiver_pct);
		send_idle_pct = sender_pct;
		recv_stall_pct = receiver_pct;
	endtask

	task automatic test_directed_events();
		send_event(make_req(sts_pkg::EV_HB_MISS, 32'h0000_0000));
		send_event(make_req(sts_pkg::EV_HB_RECOVER, 32'hFFFF_FFFF));
		send_event(make_req(sts_pkg::EV_BOOT_DONE, 32'h0000_0010));
		send_event(make_req(sts_pkg::EV_RESUME, 32'h0000_0020));
		send_event(make_req(EV_UNUSED_LO, 32'h5555_5555));
		send_event(make_req(EV_UNUSED_HI, 32'hAAAA_AAAA));
		send_event(make_req(sts_pkg::EV_ESTOP, 32'h0000_0100));
		send_event(make_req(sts_pkg::EV_BOOT_DONE, 32'h0000_0110));
		send_event(make_req(EV_UNUSED_HI, 32'h0000_0120));
		send_event(make_req(sts_pkg::EV_HB_RECOVER, 32'h0000_0130));
		send_event(make_req(sts_pkg::EV_OVERCURRENT, 32'h0000_0140));
		send_event(make_req(sts_pkg::EV_RESUME, 32'h0000_0150));
		send_event(make_req(sts_pkg::EV_WATCHDOG, 32'h0000_0160));
		send_event(make_req(sts_pkg::EV_SENSOR_FAIL, 32'h0000_0170));
		send_event(make_req(sts_pkg::EV_HB_MISS, 32'h0000_0180));
		send_event(make_req(sts_pkg::EV_HB_RECOVER, 32'h0000_0190));
		send_event(make_req(sts_pkg::EV_OVERCURRENT, 32'h0000_01A0));
		send_event(make_req(EV_UNUSED_LO, 32'h0000_01B0));
		// boots straddling the timestamp wrap still count as recent
		send_event(make_req(sts_pkg::EV_BOOT_DONE, 32'hFFFF_FFFF));
		send_event(make_req(sts_pkg::EV_BOOT_DONE, 32'h0000_0000));
		send_event(make_req(sts_pkg::EV_ESTOP, 32'h0000_0005));
		send_event(make_req(sts_pkg::EV_TRUST_VIOLATION, 32'h8000_0000));
		send_event(make_req(sts_pkg::EV_RESUME, 32'h8000_0001));
		send_event(make_req(sts_pkg::EV_TRUST_VIOLATION, 32'h8000_0002));
		send_event(make_req(sts_pkg::EV_HB_MISS, 32'h8000_0003));
		clock_ms = 32'h8000_0003;
	endtask

	task automatic test_register_access();
		load_boot_limits(32'hFFFF_FFFF, 3'd7);
		load_boot_limits(32'h0000_0000, 3'd0);
		load_boot_limits(32'h0000_0001, 3'd4);
		load_boot_limits(sts_pkg::WINDOW_RESET, sts_pkg::THRESH_RESET);
	endtask

	task automatic test_random_traffic();
		logic [sts_pkg::TIME_W-1:0] win_set [8];
		logic [sts_pkg::THR_W-1:0] thr_set [8];
		int idle_set [4][2];
		win_set = '{32'd600000, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1000, 32'hFFFF_FFFF,
			32'd0, 32'd50};
		thr_set = '{3'd5, 3'd0, 3'd7, 3'd1, 3'd3, 3'd6, 3'd0, 3'd2};
		win_set[6] = $urandom();
		thr_set[6] = sts_pkg::THR_W'($urandom_range(7));
		idle_set = '{'{0, 0}, '{58, 0}, '{0, 58}, '{22, 22}};
		for (int p = 0; p < 8; p++) begin
			load_boot_limits(win_set[p], thr_set[p]);
			set_idling(idle_set[p / 2][0], idle_set[p / 2][1]);
			repeat (REQ_PER_PHASE) send_event(next_random_event());
		end
	endtask

	task automatic test_backpressure();
		load_boot_limits(32'd5000, 3'd4);
		set_idling(0, 0);
		fork
			begin
				@(posedge clk);
				rsp_hold = 1'b1;
				repeat (200) @(posedge clk);
				rsp_hold = 1'b0;
			end
			repeat (40) send_event(next_random_event());
		join
		wait_idle();
		set_idling(22, 22);
		repeat (10) send_event(next_random_event());
	endtask

	task automatic test_fault_lockout();
		load_boot_limits(sts_pkg::WINDOW_RESET, sts_pkg::THRESH_RESET);
		set_idling(22, 22);
		fault_allowed = 1'b1;
		while (tier_now != sts_pkg::TIER_SAFE)
			send_event(make_req(tier_now == sts_pkg::TIER_NORMAL ? sts_pkg::EV_ESTOP :
				sts_pkg::EV_HB_MISS, clock_ms));
		// fill the whole ring with fresh boots, then a fault event must lock the tier
		for (int i = 0; i < sts_pkg::BOOT_SLOTS; i++)
			send_event(make_req(sts_pkg::EV_BOOT_DONE, clock_ms + sts_pkg::TIME_W'(i)));
		send_event(make_req(sts_pkg::EV_WATCHDOG, clock_ms + 32'd10));
		clock_ms += 32'd10;
		send_event(make_req(sts_pkg::EV_RESUME, clock_ms + 32'd1));
		repeat (20) send_event(next_random_event());
	endtask

	initial begin
		#(5_000_000);
		$display("FAIL safety_tier_state_machine");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tier_now = sts_pkg::TIER_NORMAL;
		ring_ptr = 0;
		ring_fill = 0;
		cfg_window = sts_pkg::WINDOW_RESET;
		cfg_thr = sts_pkg::THRESH_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_events();
		test_register_access();
		test_random_traffic();
		test_backpressure();
		test_fault_lockout();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS safety_tier_state_machine");
		else
			$display("FAIL safety_tier_state_machine");
		$finish;
	end

endmodule
